// ===== rtl/core/ctpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctpc_pkg
// shared types, event codes and limits of the cook timer power controller
// ----------------------------------------------------------------------------
package ctpc_pkg;

  // event codes carried in the input tuser
  localparam logic [3:0] FUNC_TICK      = 4'd0;
  localparam logic [3:0] FUNC_POWER     = 4'd1;
  localparam logic [3:0] FUNC_START     = 4'd2;
  localparam logic [3:0] FUNC_MINUS1    = 4'd3;
  localparam logic [3:0] FUNC_PLUS1     = 4'd4;
  localparam logic [3:0] FUNC_MINUS10   = 4'd5;
  localparam logic [3:0] FUNC_PLUS10    = 4'd6;
  localparam logic [3:0] FUNC_ROT_RIGHT = 4'd7;
  localparam logic [3:0] FUNC_ROT_LEFT  = 4'd8;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_DUTY   = 2'd0;
  localparam logic [1:0] CFG_STEP_DUTY  = 2'd1;
  localparam logic [1:0] CFG_LIGHT_THR  = 2'd2;

  localparam logic [15:0] MAX_SECONDS   = 16'd5999;
  localparam logic [11:0] DUTY_CAP      = 12'd4095;
  localparam logic [15:0] TIME_RESET    = 16'd10;
  localparam logic [9:0]  MIN_DUTY_RST  = 10'd300;
  localparam logic [7:0]  STEP_DUTY_RST = 8'd100;
  localparam logic [15:0] LIGHT_THR_RST = 16'd30;
  localparam logic [3:0]  DIGIT_MAX     = 4'd9;

  typedef struct packed {
    logic [15:0] time_count;
    logic [2:0]  power_level;
    logic        running;
    logic [3:0]  digit;
  } ctpc_state_t;

  typedef struct packed {
    logic [9:0]  min_duty;
    logic [7:0]  step_duty;
    logic [15:0] light_thr;
  } ctpc_cfg_t;

  typedef struct packed {
    logic        alarm;
    logic [3:0]  dial_digit;
    logic [15:0] seconds_left;
    logic        is_running;
    logic [7:0]  level_leds;
    logic [11:0] motor_duty;
  } ctpc_result_t;

endpackage

// ===== rtl/core/cook_timer_power_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cook_timer_power_controller
// heater timer: countdown, power level, run control and rotary digit
// ----------------------------------------------------------------------------
// usage
//   input stream: one beat per debounced event; in_tuser carries the event
//   code, in_tdata the light level (only looked at by the one-second tick)
//   output stream: one beat per event showing duty, level bar, run flag,
//   seconds left, dial digit and the alarm pulse after that event
//   config port: cfg_we writes register cfg_index (0 min duty, 1 step duty,
//   2 light threshold); write only while no event is in flight
//   path: an accepted beat waits in the input register, then moves to the
//   result register (two register stages) and is offered on out_tvalid
//   throughput: one event per cycle while out_tready stays high; the state
//   update (single add or compare, 3x8 duty multiply) lies between the stages
//   stall: when the receiver holds out_tready low the result register keeps
//   its beat, the input register fills, then in_tready drops; no beat lost
//   reset: rst_n low clears both stages and loads time 10 s, level 0, idle,
//   digit 0 and the default config (300, 100, 30)
// ----------------------------------------------------------------------------
module cook_timer_power_controller
  import ctpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input beat
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] light_level
  input  logic [3:0]  in_tuser,   // [3:0] func
  // result beat
  output logic        out_tvalid,
  input  logic        out_tready,
  // [11:0] motor_duty, [19:12] level_leds, [20] is_running,
  // [36:21] seconds_left, [40:37] dial_digit, [41] alarm, [47:42] zero
  output logic [47:0] out_tdata,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // input register
  logic         in_valid_r;
  logic [3:0]   func_r;
  logic [15:0]  light_r;

  // result register
  logic         out_valid_r;
  ctpc_result_t result_r;

  ctpc_state_t  state_r;
  ctpc_state_t  state_nxt;
  ctpc_cfg_t    cfg_r;
  ctpc_result_t result_nxt;

  logic         advance;
  logic         in_take;

  // an event moves on when the result slot is free or being drained
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  ctpc_event u_event (
    .state       (state_r),
    .cfg         (cfg_r),
    .func        (func_r),
    .light_level (light_r),
    .state_nxt   (state_nxt),
    .result      (result_nxt)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      func_r  <= in_tuser;
      light_r <= in_tdata;
    end
  end

  // controller state, updated once per event
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.time_count  <= TIME_RESET;
      state_r.power_level <= 3'd0;
      state_r.running     <= 1'b0;
      state_r.digit       <= 4'd0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  // configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_duty  <= MIN_DUTY_RST;
      cfg_r.step_duty <= STEP_DUTY_RST;
      cfg_r.light_thr <= LIGHT_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_DUTY:  cfg_r.min_duty  <= cfg_data[9:0];
        CFG_STEP_DUTY: cfg_r.step_duty <= cfg_data[7:0];
        CFG_LIGHT_THR: cfg_r.light_thr <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, result_r};

  // the alarm only comes with the tick that ends a run
  a_alarm_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.alarm |-> !result_r.is_running)
    else $error("alarm raised while still running");

  // state moves only when an event passes to the result stage
  a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("controller state changed without an event");

  // an empty input register always takes a beat
  a_ready_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_tready)
    else $error("input stalled with an empty input register");

  // the level bar is always a run of ones from the bottom
  a_leds_bar : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot({1'b0, result_r.level_leds} + 9'd1))
    else $error("level bar is not contiguous");

endmodule

// ===== rtl/core/ctpc_event.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctpc_event
// next-state and result logic for one event
// ----------------------------------------------------------------------------
module ctpc_event
  import ctpc_pkg::*;
(
  input  ctpc_state_t  state,
  input  ctpc_cfg_t    cfg,
  input  logic [3:0]   func,
  input  logic [15:0]  light_level,
  output ctpc_state_t  state_nxt,
  output ctpc_result_t result
);

  logic [16:0] sum_plus1;
  logic [16:0] sum_plus10;
  logic [10:0] level_duty;
  logic [12:0] duty_sum;
  logic        alarm;

  assign sum_plus1  = {1'b0, state.time_count} + 17'd1;
  assign sum_plus10 = {1'b0, state.time_count} + 17'd10;

  always_comb begin
    state_nxt = state;
    alarm     = 1'b0;
    unique case (func)
      FUNC_TICK: begin
        if (state.running) begin
          if (state.time_count == 16'd0) begin
            state_nxt.running = 1'b0;
            alarm             = light_level > cfg.light_thr;
          end else begin
            state_nxt.time_count = state.time_count - 16'd1;
          end
        end
      end
      FUNC_POWER: begin
        state_nxt.power_level = state.power_level + 3'd1;
      end
      FUNC_START: begin
        if (state.running) begin
          state_nxt.running = 1'b0;
        end else if (state.time_count != 16'd0) begin
          state_nxt.running = 1'b1;
        end
      end
      FUNC_MINUS1: begin
        if (!state.running && state.time_count != 16'd0) begin
          state_nxt.time_count = state.time_count - 16'd1;
        end
      end
      FUNC_PLUS1: begin
        if (!state.running) begin
          state_nxt.time_count = (sum_plus1 > {1'b0, MAX_SECONDS}) ?
                                 MAX_SECONDS : sum_plus1[15:0];
        end
      end
      FUNC_MINUS10: begin
        if (!state.running && state.time_count >= 16'd10) begin
          state_nxt.time_count = state.time_count - 16'd10;
        end
      end
      FUNC_PLUS10: begin
        if (!state.running) begin
          state_nxt.time_count = (sum_plus10 > {1'b0, MAX_SECONDS}) ?
                                 MAX_SECONDS : sum_plus10[15:0];
        end
      end
      FUNC_ROT_RIGHT: begin
        if (!state.running) begin
          state_nxt.digit = (state.digit >= DIGIT_MAX) ? 4'd0 : state.digit + 4'd1;
        end
      end
      FUNC_ROT_LEFT: begin
        if (!state.running) begin
          state_nxt.digit = (state.digit == 4'd0 || state.digit > DIGIT_MAX) ?
                            DIGIT_MAX : state.digit - 4'd1;
        end
      end
      default: begin
        // unused codes leave the state alone
      end
    endcase
  end

  // duty from the updated state
  assign level_duty = state_nxt.running ?
                      11'(state_nxt.power_level * cfg.step_duty) : 11'd0;
  assign duty_sum   = {3'b000, cfg.min_duty} + {2'b00, level_duty};

  always_comb begin
    result.motor_duty   = (duty_sum > {1'b0, DUTY_CAP}) ? DUTY_CAP : duty_sum[11:0];
    result.level_leds   = 8'hFF >> (3'd7 - state_nxt.power_level);
    result.is_running   = state_nxt.running;
    result.seconds_left = state_nxt.time_count;
    result.dial_digit   = state_nxt.digit;
    result.alarm        = alarm;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the cook timer power controller
// ----------------------------------------------------------------------------
// A short table of events comes first. It covers the reset readout, the
// unused event codes, rotary wrap, the time floors, start with no time,
// ignored edits while running and the end of a run with and without the
// alarm. Readouts that are plain to see are typed into the table. All other
// beats are checked against a cycle-free model of the timer kept in this
// bench. Random phases follow under several duty and threshold settings.
// Most of them are full cook cycles (set time, start, tick down to the end),
// mixed with bursts of noise. A last phase climbs the timer to its ceiling.
// ----------------------------------------------------------------------------
module tb;
  import ctpc_pkg::*;

  // ---------------------------------------------------------------- dut pins
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // [15:0] light_level
  logic [3:0]  in_tuser   = '0;   // [3:0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [11:0] motor_duty, [19:12] level_leds, [20] is_running,
  // [36:21] seconds_left, [40:37] dial_digit, [41] alarm, [47:42] zero
  logic [47:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [15:0] cfg_data   = '0;

  cook_timer_power_controller u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ------------------------------------------------------- timer model state
  logic [15:0] cook_secs;
  logic [2:0]  cook_level;
  logic        cook_on;
  logic [3:0]  cook_digit;
  // mirrored settings
  logic [9:0]  duty_floor;
  logic [7:0]  duty_per_level;
  logic [15:0] alarm_light_thr;

  // readouts still owed by the block, oldest first
  ctpc_result_t readout_q[$];

  // when set, neither side idles
  logic        calm = 1'b0;
  int unsigned events_sent = 0;
  int unsigned beat_no     = 0;
  int unsigned faults      = 0;
  ctpc_result_t seen, owed;

  // one event applied to the model, readout after it
  function automatic ctpc_result_t next_readout(input logic [3:0] func,
                                                input logic [15:0] light);
    ctpc_result_t r;
    int           duty;
    logic [8:0]   bar;
    r.alarm = 1'b0;
    case (func)
      FUNC_TICK: begin
        if (cook_on) begin
          if (cook_secs == 16'd0) begin
            // run ends here; alarm only in enough light
            cook_on = 1'b0;
            r.alarm = (light > alarm_light_thr);
          end else begin
            cook_secs = cook_secs - 16'd1;
          end
        end
      end
      FUNC_POWER: cook_level = cook_level + 3'd1;   // 7 wraps to 0
      FUNC_START: begin
        if (cook_on) cook_on = 1'b0;
        else if (cook_secs != 16'd0) cook_on = 1'b1;
      end
      FUNC_MINUS1: begin
        if (!cook_on && cook_secs != 16'd0) cook_secs = cook_secs - 16'd1;
      end
      FUNC_PLUS1: begin
        if (!cook_on) begin
          if (int'(cook_secs) + 1 > int'(MAX_SECONDS)) cook_secs = MAX_SECONDS;
          else cook_secs = cook_secs + 16'd1;
        end
      end
      FUNC_MINUS10: begin
        if (!cook_on && cook_secs >= 16'd10) cook_secs = cook_secs - 16'd10;
      end
      FUNC_PLUS10: begin
        if (!cook_on) begin
          if (int'(cook_secs) + 10 > int'(MAX_SECONDS)) cook_secs = MAX_SECONDS;
          else cook_secs = cook_secs + 16'd10;
        end
      end
      FUNC_ROT_RIGHT: begin
        if (!cook_on) cook_digit = (cook_digit >= DIGIT_MAX) ? 4'd0 : cook_digit + 4'd1;
      end
      FUNC_ROT_LEFT: begin
        if (!cook_on)
          cook_digit = (cook_digit == 4'd0 || cook_digit > DIGIT_MAX) ? DIGIT_MAX
                                                                     : cook_digit - 4'd1;
      end
      default: ;   // unused codes change nothing
    endcase
    duty = int'(duty_floor);
    if (cook_on) duty = duty + int'(cook_level) * int'(duty_per_level);
    if (duty > int'(DUTY_CAP)) duty = int'(DUTY_CAP);
    bar            = (9'd2 << cook_level) - 9'd1;
    r.motor_duty   = duty[11:0];
    r.level_leds   = bar[7:0];
    r.is_running   = cook_on;
    r.seconds_left = cook_secs;
    r.dial_digit   = cook_digit;
    return r;
  endfunction

  // readout typed in by hand
  function automatic ctpc_result_t panel(input int duty, input int leds, input int run,
                                         input int secs, input int digit, input int alarm);
    ctpc_result_t r;
    r.motor_duty   = duty[11:0];
    r.level_leds   = leds[7:0];
    r.is_running   = run[0];
    r.seconds_left = secs[15:0];
    r.dial_digit   = digit[3:0];
    r.alarm        = alarm[0];
    return r;
  endfunction

  // light near the threshold half of the time, so the alarm compare is exercised
  function automatic logic [15:0] pick_light();
    int v;
    if ($urandom_range(0, 1) == 1) begin
      v = int'(alarm_light_thr) - 1 + int'($urandom_range(0, 2));
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[15:0];
    end
    return 16'($urandom);
  endfunction

  // ---------------------------------------------------------------- sender
  // one beat; an idle stretch before it unless calm; the model steps at accept
  task automatic push_event(input logic [3:0] func, input logic [15:0] light,
                            input logic pinned, input ctpc_result_t want);
    ctpc_result_t pred;
    while (!calm && $urandom_range(0, 99) < 24) begin
      in_tvalid <= 1'b0;
      in_tuser  <= 4'($urandom);
      in_tdata  <= 16'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= light;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = next_readout(func, light);
    readout_q.push_back(pinned ? want : pred);
    events_sent++;
  endtask

  task automatic send(input logic [3:0] func, input logic [15:0] light);
    push_event(func, light, 1'b0, '0);
  endtask

  // drop valid and let the block drain completely
  task automatic settle();
    in_tvalid <= 1'b0;
    while (readout_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // all three registers, only with the block drained
  task automatic write_settings(input logic [9:0] floor_v, input logic [7:0] step_v,
                                input logic [15:0] thr_v);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_DUTY;
    cfg_data  <= {6'd0, floor_v};
    @(posedge clk);
    duty_floor = floor_v;
    cfg_index <= CFG_STEP_DUTY;
    cfg_data  <= {8'd0, step_v};
    @(posedge clk);
    duty_per_level = step_v;
    cfg_index <= CFG_LIGHT_THR;
    cfg_data  <= thr_v;
    @(posedge clk);
    alarm_light_thr = thr_v;
    cfg_we <= 1'b0;
  endtask

  // a full cook cycle: knob and level fiddling, set a short time, start,
  // then tick until the run ends; a few stray events fall into the run
  task automatic cook_session();
    int n;
    int r;
    // noise may have left a run going; stop it so the time edits take
    if (cook_on) send(FUNC_START, 16'($urandom));
    n = $urandom_range(0, 3);
    repeat (n) send(($urandom_range(0, 1) == 1) ? FUNC_ROT_RIGHT : FUNC_ROT_LEFT,
                    16'($urandom));
    n = $urandom_range(0, 3);
    repeat (n) send(FUNC_POWER, 16'($urandom));
    while (cook_secs > 16'd30) send(FUNC_MINUS10, 16'($urandom));
    n = $urandom_range(0, 4);
    repeat (n) send(FUNC_MINUS1 + 4'($urandom_range(0, 3)), 16'($urandom));
    send(FUNC_START, 16'($urandom));
    while (cook_on) begin
      r = $urandom_range(0, 99);
      if (r < 3) send(FUNC_START, 16'($urandom));                         // stop early
      else if (r < 15) send(FUNC_POWER + 4'($urandom_range(0, 7)), 16'($urandom));
      else send(FUNC_TICK, pick_light());
    end
  endtask

  // random phase of roughly the given number of events
  task automatic run_phase(input int unsigned count);
    int unsigned first;
    int          n;
    first = events_sent;
    while (events_sent - first < count) begin
      if ($urandom_range(0, 99) < 70) begin
        cook_session();
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send(4'($urandom_range(0, 15)), 16'($urandom));
      end
    end
  endtask

  // ------------------------------------------------------------ directed table
  typedef struct packed {
    logic [3:0]   func;
    logic [15:0]  light;
    logic         pinned;
    ctpc_result_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 24;
  dir_row_t dir_rows [0:DIR_ROWS-1];

  // -------------------------------------------------------------- receiver
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 24);
  end

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      faults++;
      if (faults <= 10)
        $display("%0t beat %0d: %s expected %0d got %0d", $time, beat_no, name,
                 want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (readout_q.size() == 0) begin
        faults++;
        if (faults <= 10) $display("%0t beat %0d: no readout owed", $time, beat_no);
      end else begin
        owed = readout_q.pop_front();
        seen = out_tdata[41:0];
        check_field("motor_duty",   owed.motor_duty,   seen.motor_duty);
        check_field("level_leds",   owed.level_leds,   seen.level_leds);
        check_field("is_running",   owed.is_running,   seen.is_running);
        check_field("seconds_left", owed.seconds_left, seen.seconds_left);
        check_field("dial_digit",   owed.dial_digit,   seen.dial_digit);
        check_field("alarm",        owed.alarm,        seen.alarm);
        check_field("pad",          0,                 out_tdata[47:42]);
      end
      beat_no++;
    end
  end

  // ------------------------------------------------------------------- main
  initial begin
    // model after reset
    cook_secs       = TIME_RESET;
    cook_level      = 3'd0;
    cook_on         = 1'b0;
    cook_digit      = 4'd0;
    duty_floor      = MIN_DUTY_RST;
    duty_per_level  = STEP_DUTY_RST;
    alarm_light_thr = LIGHT_THR_RST;

    // defaults 300 / 100 / 30, time 10 s at the start
    dir_rows[0]  = {FUNC_TICK,      16'h0000, 1'b1, panel(300, 1, 0, 10, 0, 0)};
    dir_rows[1]  = {4'hF,           16'hFFFF, 1'b1, panel(300, 1, 0, 10, 0, 0)};
    dir_rows[2]  = {4'h9,           16'h0000, 1'b1, panel(300, 1, 0, 10, 0, 0)};
    dir_rows[3]  = {FUNC_ROT_LEFT,  16'h0000, 1'b1, panel(300, 1, 0, 10, 9, 0)};  // 0 -> 9
    dir_rows[4]  = {FUNC_ROT_RIGHT, 16'hFFFF, 1'b1, panel(300, 1, 0, 10, 0, 0)};  // 9 -> 0
    dir_rows[5]  = {FUNC_MINUS10,   16'h0000, 1'b1, panel(300, 1, 0, 0, 0, 0)};
    dir_rows[6]  = {FUNC_MINUS1,    16'h0000, 1'b1, panel(300, 1, 0, 0, 0, 0)};   // floor
    dir_rows[7]  = {FUNC_MINUS10,   16'h0000, 1'b1, panel(300, 1, 0, 0, 0, 0)};   // floor
    dir_rows[8]  = {FUNC_START,     16'h0000, 1'b1, panel(300, 1, 0, 0, 0, 0)};   // no time
    dir_rows[9]  = {FUNC_PLUS1,     16'h5A5A, 1'b0, 42'd0};
    dir_rows[10] = {FUNC_START,     16'h0000, 1'b1, panel(300, 1, 1, 1, 0, 0)};
    dir_rows[11] = {FUNC_POWER,     16'h0000, 1'b1, panel(400, 3, 1, 1, 0, 0)};   // duty follows
    // edits and rotary are ignored while running
    dir_rows[12] = {FUNC_PLUS10,    16'hA5A5, 1'b0, 42'd0};
    dir_rows[13] = {FUNC_MINUS1,    16'h0000, 1'b0, 42'd0};
    dir_rows[14] = {FUNC_ROT_LEFT,  16'h0000, 1'b0, 42'd0};
    dir_rows[15] = {FUNC_TICK,      16'hFFFF, 1'b0, 42'd0};
    // tick at zero above the threshold: run ends with the alarm
    dir_rows[16] = {FUNC_TICK,      16'd31,   1'b1, panel(300, 3, 0, 0, 0, 1)};
    dir_rows[17] = {FUNC_PLUS1,     16'h0000, 1'b0, 42'd0};
    dir_rows[18] = {FUNC_START,     16'h0000, 1'b0, 42'd0};
    dir_rows[19] = {FUNC_TICK,      16'h0000, 1'b0, 42'd0};
    // light equal to the threshold: run ends quietly
    dir_rows[20] = {FUNC_TICK,      16'd30,   1'b1, panel(300, 3, 0, 0, 0, 0)};
    dir_rows[21] = {FUNC_PLUS10,    16'h0000, 1'b0, 42'd0};
    dir_rows[22] = {FUNC_START,     16'h0000, 1'b0, 42'd0};
    // start/stop while running stops the run
    dir_rows[23] = {FUNC_START,     16'h0000, 1'b1, panel(300, 3, 0, 10, 0, 0)};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      push_event(dir_rows[i].func, dir_rows[i].light, dir_rows[i].pinned, dir_rows[i].want);

    // low extremes: flat duty of zero, any light above zero alarms
    write_settings(10'd0, 8'd0, 16'd0);
    run_phase(330);
    // high extremes: alarm can never sound
    write_settings(10'd1000, 8'd255, 16'hFFFF);
    run_phase(330);
    // random settings, no idling on either side
    calm = 1'b1;
    write_settings(10'($urandom_range(0, 1000)), 8'($urandom), 16'($urandom));
    run_phase(330);
    calm = 1'b0;
    write_settings(10'd1000, 8'd255, 16'd0);
    run_phase(330);

    // climb to the ceiling with +10, some +1 and stray codes on the way
    write_settings(10'($urandom_range(0, 1000)), 8'($urandom), 16'($urandom));
    while (cook_secs != MAX_SECONDS) begin
      if (cook_on) send(FUNC_START, 16'($urandom));
      else if ($urandom_range(0, 99) < 5) send(FUNC_PLUS1, 16'($urandom));
      else if ($urandom_range(0, 99) < 3) send(4'($urandom_range(0, 15)), 16'($urandom));
      else send(FUNC_PLUS10, 16'($urandom));
    end
    // saturation at the top, then a short run and a stop
    repeat (3) send(FUNC_PLUS1, 16'($urandom));
    repeat (3) send(FUNC_PLUS10, 16'($urandom));
    send(FUNC_MINUS1, 16'($urandom));
    send(FUNC_PLUS1, 16'($urandom));
    send(FUNC_START, 16'($urandom));
    repeat (5) send(FUNC_TICK, 16'($urandom));
    send(FUNC_START, 16'($urandom));

    // drain, then a few cycles to catch any stray beat
    in_tvalid <= 1'b0;
    while (readout_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (faults == 0) begin
      $display("cook_timer_power_controller: match");
    end else begin
      $display("cook_timer_power_controller: mismatch");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("cook_timer_power_controller: mismatch");
    $finish;
  end

endmodule
